/* src/photon_random_walk_slab_core_assert.svh */
// Assertion macros shared by the photon walk modules.
// Each macro expects clk and rst in the scope where it is used.
`ifndef PHOTON_RANDOM_WALK_SLAB_CORE_ASSERT_SVH
`define PHOTON_RANDOM_WALK_SLAB_CORE_ASSERT_SVH
`ifndef SYNTH
`define PRWS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("photon walk check failed");
`define PRWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("photon walk check failed");
`else
`define PRWS_ASSERT(label, ante, cons)
`define PRWS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* src/prws_pkg.sv */
`default_nettype none
package prws_pkg;

  // Default table resolutions; both must be powers of two.
  localparam int LOG_TABLE_DEPTH_DEF = 1024;
  localparam int COS_TABLE_DEPTH_DEF = 1024;

  // Fixed-point constants.
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [19:0] COUNT_MAX  = 20'hF_FFFF;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MEAN_FREE_PATH = 2'd0;
  localparam logic [1:0] CFG_WALL_DISTANCE  = 2'd1;
  localparam logic [1:0] CFG_MAX_SCATTER    = 2'd2;
  localparam logic [1:0] CFG_PHOTONS        = 2'd3;

  // Photon outcome codes.
  localparam logic [1:0] OUT_MOVING    = 2'd0;
  localparam logic [1:0] OUT_REFLECTED = 2'd1;
  localparam logic [1:0] OUT_ABSORBED  = 2'd2;
  localparam logic [1:0] OUT_LIMIT     = 2'd3;

  // Datapath operation codes.
  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_INIT  = 4'd1;
  localparam logic [3:0] OP_NORM  = 4'd2;
  localparam logic [3:0] OP_SQR   = 4'd3;
  localparam logic [3:0] OP_LN2   = 4'd4;
  localparam logic [3:0] OP_LEN   = 4'd5;
  localparam logic [3:0] OP_ANGX  = 4'd6;
  localparam logic [3:0] OP_ANGX2 = 4'd7;
  localparam logic [3:0] OP_PLOAD = 4'd8;
  localparam logic [3:0] OP_PMUL  = 4'd9;
  localparam logic [3:0] OP_DIVA  = 4'd10;
  localparam logic [3:0] OP_DIVB  = 4'd11;
  localparam logic [3:0] OP_SMUL  = 4'd12;
  localparam logic [3:0] OP_CSEL  = 4'd13;
  localparam logic [3:0] OP_MOVE  = 4'd14;
  localparam logic [3:0] OP_UPD   = 4'd15;

  // Last series stage of the cosine; stages above it belong to the sine.
  localparam logic [2:0] SEL_COS_LAST = 3'd3;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] sel;
  } prws_cmd_t;

  typedef struct packed {
    logic f_norm;
    logic out_busy;
  } prws_stat_t;

  // Series divisors: cosine stages 0..3, sine stages 4..7.
  function automatic logic [6:0] div_val(input logic [2:0] sel);
    logic [6:0] d;
    case (sel)
      3'd0: d = 7'd56;
      3'd1: d = 7'd30;
      3'd2: d = 7'd12;
      3'd3: d = 7'd2;
      3'd4: d = 7'd72;
      3'd5: d = 7'd42;
      3'd6: d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor), used as a reciprocal multiplier.
  function automatic logic [31:0] div_recip(input logic [2:0] sel);
    logic [31:0] r;
    case (sel)
      3'd0: r = 32'd76695844;
      3'd1: r = 32'd143165576;
      3'd2: r = 32'd357913941;
      3'd3: r = 32'd2147483648;
      3'd4: r = 32'd59652323;
      3'd5: r = 32'd102261126;
      3'd6: r = 32'd214748364;
      default: r = 32'd715827882;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/prws_dp.sv */
`default_nettype none
module prws_dp #(
  parameter int LOG_TABLE_DEPTH = prws_pkg::LOG_TABLE_DEPTH_DEF,
  parameter int COS_TABLE_DEPTH = prws_pkg::COS_TABLE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [23:0]         cfg_wdata,
  input  wire logic [15:0]         uniform_sample,
  input  wire logic [15:0]         angle_sample,
  input  wire prws_pkg::prws_cmd_t cmd,
  input  wire logic                out_valid,
  output prws_pkg::prws_stat_t     stat,
  output logic [1:0]               photon_outcome,
  output logic signed [31:0]       photon_position,
  output logic [19:0]              reflected_total,
  output logic                     experiment_done
);
  import prws_pkg::*;

  localparam int LOG_BITS = $clog2(LOG_TABLE_DEPTH);
  localparam int COS_BITS = $clog2(COS_TABLE_DEPTH);

  // Configuration registers.
  logic [15:0] mean_free_path;
  logic [23:0] wall_distance;
  logic [11:0] max_scatterings;
  logic [19:0] photons_per_experiment;

  // Walk state.
  logic signed [31:0] position;
  logic [11:0]        step_index;
  logic [19:0]        photon_index;
  logic [19:0]        reflected_count;

  // Working registers.
  logic [31:0] f;
  logic [4:0]  k;
  logic [23:0] frac;
  logic [28:0] negln;
  logic [20:0] len;
  logic [1:0]  quad;
  logic        aneg;
  logic [29:0] mag;
  logic [29:0] x;
  logic [29:0] x2;
  logic [29:0] n;
  logic [29:0] qd;
  logic [30:0] acc;
  logic [30:0] cosv;
  logic [30:0] sn;
  logic [30:0] cm;
  logic        cneg;
  logic [21:0] disp;

  // Shared multiplier.
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_NORM, OP_SQR: begin
        mul_a = f;
        mul_b = f;
      end
      OP_LN2: begin
        mul_a = {3'b0, {k + 5'd1, 24'b0} - {5'b0, frac}};
        mul_b = LN2_Q32;
      end
      OP_LEN: begin
        mul_a = {3'b0, negln};
        mul_b = {16'b0, mean_free_path};
      end
      OP_ANGX: begin
        mul_a = {2'b0, mag};
        mul_b = TWO_PI_Q29;
      end
      OP_ANGX2: begin
        mul_a = {2'b0, x};
        mul_b = {2'b0, x};
      end
      OP_PMUL: begin
        mul_a = {2'b0, x2};
        mul_b = {1'b0, acc};
      end
      OP_DIVA: begin
        mul_a = {2'b0, n};
        mul_b = div_recip(cmd.sel);
      end
      OP_SMUL: begin
        mul_a = {2'b0, x};
        mul_b = {1'b0, acc};
      end
      OP_MOVE: begin
        mul_a = {11'b0, len};
        mul_b = {1'b0, cm};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Rounded product views.
  logic [63:0] prod_r23;
  logic [63:0] prod_r29;
  logic [63:0] prod_r30;
  logic [63:0] prod_r31;
  logic [32:0] sq;

  assign prod_r23 = prod + 64'h80_0000;
  assign prod_r29 = prod + 64'h2000_0000;
  assign prod_r30 = prod + 64'h4000_0000;
  assign prod_r31 = prod + 64'h8000_0000;
  assign sq       = prod[63:31];

  // Input decode: log table bin and angle turn.
  logic [15:0] u_eff;
  logic [31:0] f_init;
  logic [31:0] turn;
  logic [31:0] turn_s;
  logic [29:0] turn_lo;

  assign u_eff   = (uniform_sample == 16'd0) ? 16'd1 : uniform_sample;
  assign f_init  = {u_eff[15:16-LOG_BITS], 1'b1, {(31 - LOG_BITS){1'b0}}};
  assign turn    = {angle_sample[15:16-COS_BITS], {(32 - COS_BITS){1'b0}}};
  assign turn_s  = turn + 32'h2000_0000;
  assign turn_lo = turn_s[29:0];

  // Reciprocal division correction.
  logic [31:0] dval32;
  logic [31:0] div_rem;
  logic [36:0] qd_times_d;
  logic [30:0] quot;

  assign dval32     = {25'b0, div_val(cmd.sel)};
  assign qd_times_d = qd * div_val(cmd.sel);
  assign div_rem    = {2'b0, n} - qd_times_d[31:0];
  assign quot       = {1'b0, qd} + ((div_rem >= dval32) ? 31'd1 : 31'd0);

  // Step update: move, saturate, classify.
  logic signed [33:0] disp_s;
  logic signed [33:0] np_wide;
  logic [31:0]        np_sat;
  logic [12:0]        steps;
  logic [20:0]        photon_next;
  logic [1:0]         outcome;
  logic [19:0]        refl_total;
  logic               last_photon;

  always_comb begin
    disp_s  = cneg ? -$signed({12'b0, disp}) : $signed({12'b0, disp});
    np_wide = $signed({{2{position[31]}}, position}) + disp_s;
    if ((np_wide[33:31] == 3'b000) || (np_wide[33:31] == 3'b111)) begin
      np_sat = np_wide[31:0];
    end else if (np_wide[33]) begin
      np_sat = 32'h8000_0000;
    end else begin
      np_sat = 32'h7FFF_FFFF;
    end
    steps       = {1'b0, step_index} + 13'd1;
    photon_next = {1'b0, photon_index} + 21'd1;
    last_photon = photon_next >= {1'b0, photons_per_experiment};
    if (np_sat[31]) begin
      outcome = OUT_REFLECTED;
    end else if (np_sat > {8'b0, wall_distance}) begin
      outcome = OUT_ABSORBED;
    end else if (steps >= {1'b0, max_scatterings}) begin
      outcome = OUT_LIMIT;
    end else begin
      outcome = OUT_MOVING;
    end
    if ((outcome == OUT_REFLECTED) && (reflected_count != COUNT_MAX)) begin
      refl_total = reflected_count + 20'd1;
    end else begin
      refl_total = reflected_count;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_free_path         <= 16'd256;
      wall_distance          <= 24'd2560;
      max_scatterings        <= 12'd99;
      photons_per_experiment <= 20'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MEAN_FREE_PATH: mean_free_path <= cfg_wdata[15:0];
        CFG_WALL_DISTANCE:  wall_distance <= cfg_wdata;
        CFG_MAX_SCATTER:    max_scatterings <= cfg_wdata[11:0];
        CFG_PHOTONS:        photons_per_experiment <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  // Walk state, updated once per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= '0;
      step_index      <= '0;
      photon_index    <= '0;
      reflected_count <= '0;
    end else if (cmd.op == OP_UPD) begin
      if (outcome == OUT_MOVING) begin
        position   <= np_sat;
        step_index <= steps[11:0];
      end else begin
        position   <= '0;
        step_index <= '0;
        if (last_photon) begin
          photon_index    <= '0;
          reflected_count <= '0;
        end else begin
          photon_index    <= photon_next[19:0];
          reflected_count <= refl_total;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_UPD) begin
      photon_outcome  <= outcome;
      photon_position <= np_sat;
      reflected_total <= refl_total;
      experiment_done <= (outcome != OUT_MOVING) && last_photon;
    end
  end

  // Working registers, one operation per cycle.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INIT: begin
        f    <= f_init;
        k    <= '0;
        frac <= '0;
        quad <= turn_s[31:30];
        aneg <= ~turn_lo[29];
        mag  <= turn_lo[29] ? (turn_lo - 30'h2000_0000) : (30'h2000_0000 - turn_lo);
      end
      OP_NORM: begin
        f <= {f[30:0], 1'b0};
        k <= k + 5'd1;
      end
      OP_SQR: begin
        f    <= sq[32] ? sq[32:1] : sq[31:0];
        frac <= {frac[22:0], sq[32]};
      end
      OP_LN2:   negln <= prod_r31[60:32];
      OP_LEN:   len <= prod_r23[44:24];
      OP_ANGX:  x <= prod_r30[60:31];
      OP_ANGX2: x2 <= prod[59:30];
      OP_PLOAD: n <= x2;
      OP_PMUL:  n <= prod[59:30];
      OP_DIVA:  qd <= prod[61:32];
      OP_DIVB: begin
        acc <= ONE_Q30 - quot;
        if (cmd.sel == SEL_COS_LAST) begin
          cosv <= ONE_Q30 - quot;
        end
      end
      OP_SMUL: sn <= prod[60:30];
      OP_CSEL: begin
        if (step_index == 12'd0) begin
          cm   <= ONE_Q30;
          cneg <= 1'b0;
        end else begin
          case (quad)
            2'd0: begin
              cm   <= cosv;
              cneg <= 1'b0;
            end
            2'd1: begin
              cm   <= sn;
              cneg <= ~aneg;
            end
            2'd2: begin
              cm   <= cosv;
              cneg <= 1'b1;
            end
            default: begin
              cm   <= sn;
              cneg <= aneg;
            end
          endcase
        end
      end
      OP_MOVE: disp <= prod_r29[51:30];
      default: ;
    endcase
  end

  assign stat.f_norm   = f[31];
  assign stat.out_busy = out_valid;

`include "photon_random_walk_slab_core_assert.svh"

  // Squaring needs a mantissa in [1, 2).
  `PRWS_ASSERT(a_sqr_norm, (cmd.op == OP_SQR), f[31])
  // The reciprocal quotient is off by at most one.
  `PRWS_ASSERT(a_div_corr, (cmd.op == OP_DIVB), (div_rem < (dval32 + dval32)))
  // A moving photon never sits outside the slab.
  `PRWS_ASSERT_NEXT(a_moving_inside, (cmd.op == OP_UPD) && (outcome == OUT_MOVING),
                    !position[31])

endmodule
`default_nettype wire

/* src/prws_ctrl.sv */
`default_nettype none
module prws_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  input  wire prws_pkg::prws_stat_t stat,
  output prws_pkg::prws_cmd_t       cmd
);
  import prws_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NORM  = 4'd1;
  localparam logic [3:0] S_SQR   = 4'd2;
  localparam logic [3:0] S_LN2   = 4'd3;
  localparam logic [3:0] S_LEN   = 4'd4;
  localparam logic [3:0] S_ANGX  = 4'd5;
  localparam logic [3:0] S_ANGX2 = 4'd6;
  localparam logic [3:0] S_PNUM  = 4'd7;
  localparam logic [3:0] S_DIVA  = 4'd8;
  localparam logic [3:0] S_DIVB  = 4'd9;
  localparam logic [3:0] S_SMUL  = 4'd10;
  localparam logic [3:0] S_CSEL  = 4'd11;
  localparam logic [3:0] S_MOVE  = 4'd12;
  localparam logic [3:0] S_UPD   = 4'd13;

  localparam logic [4:0] SQR_LAST  = 5'd23;
  localparam logic [4:0] POLY_LAST = 5'd7;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [4:0] cnt;
  logic [4:0] cnt_next;
  logic       out_valid;
  logic       out_valid_next;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;

  // Sequencer: one datapath operation per cycle, but none while idle, on leaving normalization, or while S_UPD waits.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = OP_NOP;
    cmd.sel    = cnt[2:0];
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.op     = OP_INIT;
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (stat.f_norm) begin
          cnt_next   = '0;
          state_next = S_SQR;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      S_SQR: begin
        cmd.op = OP_SQR;
        if (cnt == SQR_LAST) begin
          cnt_next   = '0;
          state_next = S_LN2;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_LN2: begin
        cmd.op     = OP_LN2;
        state_next = S_LEN;
      end
      S_LEN: begin
        cmd.op     = OP_LEN;
        state_next = S_ANGX;
      end
      S_ANGX: begin
        cmd.op     = OP_ANGX;
        state_next = S_ANGX2;
      end
      S_ANGX2: begin
        cmd.op     = OP_ANGX2;
        cnt_next   = '0;
        state_next = S_PNUM;
      end
      S_PNUM: begin
        cmd.op     = (cnt[1:0] == 2'd0) ? OP_PLOAD : OP_PMUL;
        state_next = S_DIVA;
      end
      S_DIVA: begin
        cmd.op     = OP_DIVA;
        state_next = S_DIVB;
      end
      S_DIVB: begin
        cmd.op = OP_DIVB;
        if (cnt == POLY_LAST) begin
          state_next = S_SMUL;
        end else begin
          cnt_next   = cnt + 5'd1;
          state_next = S_PNUM;
        end
      end
      S_SMUL: begin
        cmd.op     = OP_SMUL;
        state_next = S_CSEL;
      end
      S_CSEL: begin
        cmd.op     = OP_CSEL;
        state_next = S_MOVE;
      end
      S_MOVE: begin
        cmd.op     = OP_MOVE;
        state_next = S_UPD;
      end
      S_UPD: begin
        // Wait until the result register is free or being emptied.
        if (!stat.out_busy || m_axis_tready) begin
          cmd.op     = OP_UPD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.op == OP_UPD) begin
      out_valid_next = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

`include "photon_random_walk_slab_core_assert.svh"

  // A new result never overwrites one that is still waiting.
  `PRWS_ASSERT(a_no_overwrite, (cmd.op == OP_UPD), (!out_valid || m_axis_tready))
  // The squaring loop stays within its 24 passes.
  `PRWS_ASSERT(a_sqr_count, (state == S_SQR), (cnt <= SQR_LAST))
  // Loading a result always raises valid on the next cycle.
  `PRWS_ASSERT_NEXT(a_out_raise, (cmd.op == OP_UPD), out_valid)

endmodule
`default_nettype wire

/* src/photon_random_walk_slab_core.sv */
`default_nettype none
// One-dimensional slab photon walk. Each input item is one scattering step of
// the current photon and yields one result item: outcome, new position,
// reflected count of the running experiment, and tlast when the step ends
// the experiment's last photon. The time from acceptance to a ready result
// grows with k (0 to log2(LOG_TABLE_DEPTH)), the normalizing shift of the
// log-table bin of the uniform sample. One shared 32x32 multiplier carries
// 24 squaring passes for the logarithm and an eight-stage cosine/sine
// series with reciprocal division. One item is in flight at a time; the next
// is taken while a finished result waits. Both table depths must be powers
// of two. Configuration is written through cfg_we/cfg_index/cfg_wdata while
// no item is in flight.
module photon_random_walk_slab_core #(
  parameter int LOG_TABLE_DEPTH = prws_pkg::LOG_TABLE_DEPTH_DEF,
  parameter int COS_TABLE_DEPTH = prws_pkg::COS_TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0: uniform_sample[15:0], angle_sample[31:16].
  input  wire logic [31:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // Fields from bit 0: photon_position[31:0], reflected_total[51:32], zero fill.
  output logic [55:0]      m_axis_tdata,
  // Fields from bit 0: photon_outcome[1:0].
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);
  import prws_pkg::*;

  prws_cmd_t          cmd;
  prws_stat_t         stat;
  logic signed [31:0] photon_position;
  logic [19:0]        reflected_total;

  prws_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  prws_dp #(
    .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH),
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .uniform_sample  (s_axis_tdata[15:0]),
    .angle_sample    (s_axis_tdata[31:16]),
    .cmd             (cmd),
    .out_valid       (m_axis_tvalid),
    .stat            (stat),
    .photon_outcome  (m_axis_tuser),
    .photon_position (photon_position),
    .reflected_total (reflected_total),
    .experiment_done (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, reflected_total, photon_position};

endmodule
`default_nettype wire

/* tb/tb.sv */
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prws_pkg::*;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [31:0] position;
    logic [19:0] total;
    logic        done;
  } step_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_MEAN_FREE_PATH;
  logic [23:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // Fields from bit 0: uniform_sample[15:0], angle_sample[31:16].
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // Fields from bit 0: photon_position[31:0], reflected_total[51:32], zero fill.
  logic [55:0] m_axis_tdata;
  // Fields from bit 0: photon_outcome[1:0].
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  photon_random_walk_slab_core DUT (.*);

  always #10 clk = ~clk;

  // Mirror of the configuration and the walk state.
  logic [15:0] mfp_r = 16'd256;
  logic [23:0] wall_r = 24'd2560;
  logic [11:0] max_steps_r = 12'd99;
  logic [19:0] ppe_r = 20'd1000;
  int          walk_pos = 0;
  logic [11:0] walk_steps = '0;
  logic [19:0] walk_photon = '0;
  logic [19:0] walk_reflected = '0;

  step_result_t expected_steps[$];
  int errors = 0;
  int results_seen = 0;
  int photons_ended = 0;
  int experiments_done = 0;
  int burst_left = 0;
  int stall_mode = 0;

  // -ln(u) in Q8.24 from the log bin centre.
  function automatic longint unsigned neg_ln_q24(input logic [15:0] u);
    longint unsigned idx, f, frac, nl2;
    int k;
    frac = 0;
    k = 0;
    if (u == 0) u = 16'd1;
    idx = (64'(u) * 1024) >> 16;
    f = ((2 * idx + 1) << 31) / 1024;
    while (f < (64'd1 << 31)) begin
      f = f << 1;
      k++;
    end
    for (int b = 0; b < 24; b++) begin
      f = (f * f) >> 31;
      frac = frac << 1;
      if (f >= (64'd1 << 32)) begin
        f = f >> 1;
        frac = frac | 1;
      end
    end
    nl2 = (64'(k + 1) << 24) - frac;
    return (nl2 * 64'd2977044472 + (64'd1 << 31)) >> 32;
  endfunction

  function automatic longint unsigned mul30(input longint unsigned a, b);
    return (a * b) >> 30;
  endfunction

  // Cosine of a turn fraction in signed Q2.30.
  function automatic longint cos_q30(input logic [15:0] angle);
    logic [31:0] t, s;
    logic [1:0] q;
    longint d, cs, ss;
    longint unsigned mag, x, x2, c, sn, one;
    one = 64'd1 << 30;
    t = 32'((64'(angle >> 6) << 32) / 1024);
    s = t + (32'd1 << 29);
    q = s[31:30];
    d = longint'(s & 32'h3FFF_FFFF) - (longint'(1) << 29);
    mag = (d < 0) ? -d : d;
    x = (mag * 64'd3373259426 + (64'd1 << 30)) >> 31;
    x2 = mul30(x, x);
    c = one - x2 / 56;
    c = one - mul30(x2, c) / 30;
    c = one - mul30(x2, c) / 12;
    c = one - mul30(x2, c) / 2;
    sn = one - x2 / 72;
    sn = one - mul30(x2, sn) / 42;
    sn = one - mul30(x2, sn) / 20;
    sn = one - mul30(x2, sn) / 6;
    sn = mul30(x, sn);
    cs = c;
    ss = (d < 0) ? -longint'(sn) : longint'(sn);
    case (q)
      2'd0: return cs;
      2'd1: return -ss;
      2'd2: return -cs;
      default: return ss;
    endcase
  endfunction

  // Advances the walk by one scattering step and returns its result.
  function automatic step_result_t scatter_step(input logic [15:0] u, input logic [15:0] ang);
    step_result_t r;
    longint unsigned len, cm;
    longint c, disp, np;
    logic [12:0] steps;
    len = (neg_ln_q24(u) * mfp_r + (64'd1 << 23)) >> 24;
    c = (walk_steps == 0) ? (longint'(1) << 30) : cos_q30(ang);
    cm = (c < 0) ? -c : c;
    disp = (len * cm + (64'd1 << 29)) >> 30;
    if (c < 0) disp = -disp;
    np = longint'(walk_pos) + disp;
    if (np > 64'sd2147483647) np = 64'sd2147483647;
    if (np < -64'sd2147483648) np = -64'sd2147483648;
    steps = walk_steps + 13'd1;
    r.done = 1'b0;
    if (np < 0) begin
      r.outcome = OUT_REFLECTED;
      if (walk_reflected != COUNT_MAX) walk_reflected++;
    end else if (np > longint'(wall_r)) begin
      r.outcome = OUT_ABSORBED;
    end else if (steps >= max_steps_r) begin
      r.outcome = OUT_LIMIT;
    end else begin
      r.outcome = OUT_MOVING;
    end
    r.total = walk_reflected;
    r.position = np[31:0];
    if (r.outcome == OUT_MOVING) begin
      walk_pos = int'(np);
      walk_steps = steps[11:0];
    end else begin
      walk_pos = 0;
      walk_steps = '0;
      if (21'(walk_photon) + 21'd1 >= ppe_r) begin
        r.done = 1'b1;
        walk_photon = '0;
        walk_reflected = '0;
      end else begin
        walk_photon++;
      end
    end
    return r;
  endfunction

  // Sends one item in bursts with random gaps; predicts on acceptance.
  task automatic send_sample(input logic [15:0] u, input logic [15:0] ang);
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {ang, u};
    do @(posedge clk); while (!s_axis_tready);
    expected_steps.push_back(scatter_step(u, ang));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(0, 150)) @(negedge clk);
      end
    end
  endtask

  // Drops valid so no item is offered again, then waits for every result.
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_MEAN_FREE_PATH: mfp_r = value[15:0];
      CFG_WALL_DISTANCE: wall_r = value;
      CFG_MAX_SCATTER: max_steps_r = value[11:0];
      default: ppe_r = value[19:0];
    endcase
  endtask

  task automatic configure(input logic [15:0] mfp, input logic [23:0] wall,
                           input logic [11:0] max_steps, input logic [19:0] ppe);
    wait_drained();
    write_reg(CFG_MEAN_FREE_PATH, 24'(mfp));
    write_reg(CFG_WALL_DISTANCE, wall);
    write_reg(CFG_MAX_SCATTER, 24'(max_steps));
    write_reg(CFG_PHOTONS, 24'(ppe));
  endtask

  // Field extremes, zero sample, every quadrant, with reset settings.
  task automatic test_directed();
    logic [15:0] angles[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF);
    foreach (angles[i]) send_sample(16'h0040, angles[i]);
    send_sample(16'h0001, 16'h8000);
    send_sample(16'hFFFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
  endtask

  // Register extremes: zero and one limits, tiny and huge lengths.
  task automatic test_register_extremes();
    configure(16'd1, 24'd1, 12'd0, 20'd0);
    repeat (6) send_sample(16'($urandom), 16'($urandom));
    configure(16'hFFFF, 24'hFFFFFF, 12'd4095, 20'hFFFFF);
    repeat (8) send_sample(16'($urandom), 16'($urandom));
    configure(16'd256, 24'd2560, 12'd1, 20'd1);
    repeat (6) send_sample(16'($urandom), 16'($urandom));
  endtask

  // Pauses the sender until every expected result has come back.
  task automatic test_drain_pause();
    repeat (5) send_sample(16'($urandom), 16'($urandom));
    wait_drained();
    repeat (5) send_sample(16'($urandom), 16'($urandom));
  endtask

  // Random walks over a series of settings; the walk carries across writes.
  task automatic test_random_walks();
    for (int phase = 0; phase < 12; phase++) begin
      configure(16'($urandom_range(64, 1024)), 24'($urandom_range(256, 8192)),
                12'($urandom_range(2, 120)), 20'($urandom_range(1, 12)));
      repeat (155) begin
        if ($urandom_range(0, 19) == 0)
          send_sample(16'($urandom_range(0, 63)), 16'($urandom));
        else
          send_sample(16'($urandom), 16'($urandom));
      end
    end
  endtask

  // Receiver stall pattern: switches at random among always ready, ready half the time and rarely ready.
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      default: m_axis_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Compares each result item with the oldest prediction.
  always @(posedge clk) begin
    step_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_steps.size() == 0) begin
        $error("result item with no prediction waiting");
        errors++;
      end else begin
        want = expected_steps.pop_front();
        if (m_axis_tuser !== want.outcome) begin
          $error("photon_outcome expected %0d actual %0d", want.outcome, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[31:0] !== want.position) begin
          $error("photon_position expected %0d actual %0d",
                 $signed(want.position), $signed(m_axis_tdata[31:0]));
          errors++;
        end
        if (m_axis_tdata[51:32] !== want.total) begin
          $error("reflected_total expected %0d actual %0d", want.total, m_axis_tdata[51:32]);
          errors++;
        end
        if (m_axis_tlast !== want.done) begin
          $error("experiment_done expected %0d actual %0d", want.done, m_axis_tlast);
          errors++;
        end
        if (want.outcome != OUT_MOVING) photons_ended++;
        if (want.done) experiments_done++;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_register_extremes();
    test_drain_pause();
    test_random_walks();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Checked %0d steps: %0d photons ended, %0d experiments completed,",
             results_seen, photons_ended, experiments_done);
    $display("over default, extreme and random register settings.");
    if (errors == 0 && expected_steps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
